### sv/lrpm_pkg.sv
// ----------------------------------------------------------------------------
// lrpm_pkg
// Shared types, codes and constants of the LED ring pixel mapper.
// ----------------------------------------------------------------------------
package lrpm_pkg;

  localparam int LEDS_PER_RING        = 16;
  localparam int RINGS_ON_FIRST_STRIP = 16;
  localparam int POS_W                = (LEDS_PER_RING > 1) ? $clog2(LEDS_PER_RING) : 1;
  localparam int QUEUE_DEPTH          = 2;

  typedef enum logic [2:0] {
    KIND_RING        = 3'd0,
    KIND_RING_DOUBLE = 3'd1,
    KIND_VU          = 3'd2,
    KIND_SWITCH      = 3'd3,
    KIND_DIGITAL1    = 3'd4,
    KIND_DIGITAL2    = 3'd5,
    KIND_OTHER       = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    STRIP_RING1 = 2'd0,
    STRIP_RING2 = 2'd1,
    STRIP_DIG1  = 2'd2,
    STRIP_DIG2  = 2'd3
  } strip_e;

  typedef enum logic [2:0] {
    REG_RING_MASK_V = 3'd0,
    REG_RING_MASK_H = 3'd1,
    REG_SW_MASK_V   = 3'd2,
    REG_SW_MASK_H   = 3'd3,
    REG_DIG_COUNT   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [15:0] ring_mask_v;
    logic [15:0] ring_mask_h;
    logic [15:0] sw_mask_v;
    logic [15:0] sw_mask_h;
    logic [7:0]  dig_count;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    strip_e      strip;
    logic [11:0] base;
    logic [15:0] on_bits;
    logic [15:0] oth_bits;
    logic        vert;
    rgb_t        rgb;
  } cmd_t;

  typedef struct packed {
    logic        we;
    strip_e      strip;
    logic [11:0] idx;
    rgb_t        rgb;
    logic        last;
  } res_t;

  typedef struct packed {
    logic hit;
    rgb_t rgb;
  } zone_t;

  localparam rgb_t VU_CYAN   = '{r: 8'd9,   g: 8'd88,  b: 8'd103};
  localparam rgb_t VU_YELLOW = '{r: 8'd100, g: 8'd100, b: 8'd0};
  localparam rgb_t VU_RED    = '{r: 8'd200, g: 8'd0,   b: 8'd0};

  function automatic zone_t vu_zone(logic vert, logic [POS_W-1:0] pos);
    zone_t       z;
    int unsigned p;
    z = '{hit: 1'b0, rgb: '0};
    p = int'(pos);
    if (vert) begin
      if (p >= 13 || p <= 4) begin
        z = '{hit: 1'b1, rgb: VU_CYAN};
      end else if (p <= 7) begin
        z = '{hit: 1'b1, rgb: VU_YELLOW};
      end else if (p <= 9) begin
        z = '{hit: 1'b1, rgb: VU_RED};
      end
    end else begin
      if (p >= 1 && p <= 8) begin
        z = '{hit: 1'b1, rgb: VU_CYAN};
      end else if (p >= 9 && p <= 11) begin
        z = '{hit: 1'b1, rgb: VU_YELLOW};
      end else if (p >= 12 && p <= 13) begin
        z = '{hit: 1'b1, rgb: VU_RED};
      end
    end
    return z;
  endfunction

endpackage

### sv/lrpm_cfg.sv
// ----------------------------------------------------------------------------
// lrpm_cfg
// APB register file: ring/switch masks and digital strip offset.
// ----------------------------------------------------------------------------
module lrpm_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output lrpm_pkg::cfg_t    cfg_o
);
  import lrpm_pkg::*;

  cfg_t     cfg_q, cfg_d;
  cfg_reg_e addr;
  logic     wr_en;

  assign addr   = cfg_reg_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (addr)
        REG_RING_MASK_V: cfg_d.ring_mask_v = pwdata[15:0];
        REG_RING_MASK_H: cfg_d.ring_mask_h = pwdata[15:0];
        REG_SW_MASK_V:   cfg_d.sw_mask_v   = pwdata[15:0];
        REG_SW_MASK_H:   cfg_d.sw_mask_h   = pwdata[15:0];
        REG_DIG_COUNT:   cfg_d.dig_count   = pwdata[7:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (addr)
      REG_RING_MASK_V: prdata = {16'd0, cfg_q.ring_mask_v};
      REG_RING_MASK_H: prdata = {16'd0, cfg_q.ring_mask_h};
      REG_SW_MASK_V:   prdata = {16'd0, cfg_q.sw_mask_v};
      REG_SW_MASK_H:   prdata = {16'd0, cfg_q.sw_mask_h};
      REG_DIG_COUNT:   prdata = {24'd0, cfg_q.dig_count};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### sv/lrpm_front.sv
// ----------------------------------------------------------------------------
// lrpm_front
// Accepts requests and classifies them into sweep commands.
// ----------------------------------------------------------------------------
module lrpm_front (
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        req_type_i,
  input  logic [7:0]        target_index_i,
  input  logic              vertical_i,
  input  logic [15:0]       led_state_i,
  input  logic [7:0]        red_in_i,
  input  logic [7:0]        green_in_i,
  input  logic [7:0]        blue_in_i,
  input  lrpm_pkg::cfg_t    cfg_i,
  input  logic              q_full_i,
  output logic              push_o,
  output lrpm_pkg::cmd_t    cmd_o
);
  import lrpm_pkg::*;

  kind_e       kind;
  logic [15:0] ring_m, sw_m, own_m, oth_m;
  rgb_t        req_rgb;
  logic [11:0] ring_base;
  strip_e      ring_strip;

  assign busy   = q_full_i;
  assign push_o = start & ~q_full_i;
  assign kind   = kind_e'(req_type_i);
  assign req_rgb = '{r: red_in_i, g: green_in_i, b: blue_in_i};

  always_comb begin
    ring_m = vertical_i ? cfg_i.ring_mask_v : cfg_i.ring_mask_h;
    sw_m   = vertical_i ? cfg_i.sw_mask_v   : cfg_i.sw_mask_h;
    own_m  = (kind == KIND_SWITCH) ? sw_m : ring_m;
    oth_m  = (kind == KIND_SWITCH) ? ring_m : sw_m;
    if (int'(target_index_i) < RINGS_ON_FIRST_STRIP) begin
      ring_strip = STRIP_RING1;
      ring_base  = 12'(int'(target_index_i) * LEDS_PER_RING);
    end else begin
      ring_strip = STRIP_RING2;
      ring_base  = 12'((int'(target_index_i) - RINGS_ON_FIRST_STRIP) * LEDS_PER_RING);
    end
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.vert = vertical_i;
    case (kind)
      KIND_RING, KIND_RING_DOUBLE, KIND_VU, KIND_SWITCH: begin
        cmd_o.kind     = kind;
        cmd_o.strip    = ring_strip;
        cmd_o.base     = ring_base;
        cmd_o.on_bits  = led_state_i & own_m;
        cmd_o.oth_bits = oth_m;
        cmd_o.rgb      = req_rgb;
      end
      KIND_DIGITAL1: begin
        cmd_o.kind  = KIND_DIGITAL1;
        cmd_o.strip = STRIP_DIG1;
        cmd_o.base  = {4'd0, target_index_i};
        cmd_o.rgb   = (led_state_i != 16'd0) ? req_rgb : '0;
      end
      KIND_DIGITAL2: begin
        cmd_o.kind  = KIND_DIGITAL2;
        cmd_o.strip = STRIP_DIG2;
        cmd_o.base  = {4'd0, target_index_i} - {4'd0, cfg_i.dig_count};
        cmd_o.rgb   = (led_state_i != 16'd0) ? req_rgb : '0;
      end
      default: begin
        cmd_o.kind = KIND_OTHER;
      end
    endcase
  end

endmodule

### sv/lrpm_queue.sv
// ----------------------------------------------------------------------------
// lrpm_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module lrpm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lrpm_pkg::cmd_t    data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output lrpm_pkg::cmd_t    data_o
);
  import lrpm_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (int'(cnt_q) == QUEUE_DEPTH);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### sv/lrpm_back.sv
// ----------------------------------------------------------------------------
// lrpm_back
// Sweeps ring positions, one result per cycle, into the result register.
// ----------------------------------------------------------------------------
module lrpm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  lrpm_pkg::cmd_t    q_data_i,
  output logic              pop_o,
  output logic              strobe_o,
  output lrpm_pkg::res_t    res_o
);
  import lrpm_pkg::*;

  cmd_t             cmd_q;
  logic             active_q, active_d;
  logic [POS_W-1:0] pos_q, pos_d;
  rgb_t             carry_q, carry_d;
  logic             strobe_q;
  res_t             res_q, res_d;

  logic  is_ring, at_end, finishing, on_bit, oth_bit;
  zone_t zone;
  rgb_t  colour;

  always_comb begin
    is_ring   = (cmd_q.kind inside {KIND_RING, KIND_RING_DOUBLE, KIND_VU, KIND_SWITCH});
    at_end    = (int'(pos_q) == LEDS_PER_RING - 1);
    finishing = active_q & (~is_ring | at_end);
    pop_o     = q_valid_i & (~active_q | finishing);

    zone   = vu_zone(cmd_q.vert, pos_q);
    colour = (cmd_q.kind == KIND_VU && zone.hit) ? zone.rgb : carry_q;
    on_bit  = cmd_q.on_bits[pos_q];
    oth_bit = cmd_q.oth_bits[pos_q];

    res_d       = '0;
    res_d.strip = cmd_q.strip;
    if (is_ring) begin
      res_d.idx  = cmd_q.base + 12'(pos_q);
      res_d.last = at_end;
      if (on_bit && !oth_bit) begin
        res_d.we  = 1'b1;
        res_d.rgb = colour;
      end else if (oth_bit || cmd_q.kind == KIND_RING_DOUBLE) begin
        res_d.we = 1'b0;
      end else begin
        res_d.we = 1'b1;
      end
    end else begin
      res_d.idx  = cmd_q.base;
      res_d.rgb  = cmd_q.rgb;
      res_d.we   = (cmd_q.kind == KIND_DIGITAL1) || (cmd_q.kind == KIND_DIGITAL2);
      res_d.last = 1'b1;
    end

    active_d = active_q;
    pos_d    = pos_q;
    carry_d  = carry_q;
    if (pop_o) begin
      active_d = 1'b1;
      pos_d    = '0;
      carry_d  = q_data_i.rgb;
    end else if (finishing) begin
      active_d = 1'b0;
    end else if (active_q) begin
      pos_d   = pos_q + 1'b1;
      carry_d = colour;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pos_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      active_q <= active_d;
      pos_q    <= pos_d;
      strobe_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    if (pop_o) begin
      cmd_q <= q_data_i;
    end
    if (active_q) begin
      res_q <= res_d;
    end
  end

  assign strobe_o = strobe_q;
  assign res_o    = res_q;

  a_sweep_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && !res_q.last |-> active_q)
    else $error("ring sweep stopped before its last position");

  a_pos_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q && !finishing |=> active_q && pos_q == $past(pos_q) + 1'b1)
    else $error("ring position did not advance by one");

  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> q_valid_i && (!active_q || finishing))
    else $error("command taken while sweep still running");

endmodule

### sv/led_ring_pixel_mapper.sv
// ----------------------------------------------------------------------------
// led_ring_pixel_mapper
// Turns LED update requests into pixel writes for ring and digital strips.
// ----------------------------------------------------------------------------
// Ring, ring double, VU meter and switch requests give sixteen results, one per
// cycle from the position sequencer in the back end; digital and other
// requests give one result. A two-entry command queue lets a new request be
// taken while a sweep runs, so ring sweeps can follow one another with no gap;
// each request passes through the queue and then the command register.
// Results are strobed for one cycle and cannot be held off by the receiver.
module led_ring_pixel_mapper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  target_index_i,
  input  logic        vertical_i,
  input  logic [15:0] led_state_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic        strobe_o,
  output logic        write_enable_o,
  output logic [1:0]  strip_select_o,
  output logic [11:0] pixel_index_o,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic        last_o
);
  import lrpm_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd, head_cmd;
  res_t res;
  logic q_full, q_valid, push, pop;

  lrpm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lrpm_front u_front (
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .target_index_i (target_index_i),
    .vertical_i     (vertical_i),
    .led_state_i    (led_state_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .cfg_i          (cfg),
    .q_full_i       (q_full),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  lrpm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (head_cmd)
  );

  lrpm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (head_cmd),
    .pop_o     (pop),
    .strobe_o  (strobe_o),
    .res_o     (res)
  );

  assign write_enable_o = res.we;
  assign strip_select_o = res.strip;
  assign pixel_index_o  = res.idx;
  assign red_out_o      = res.rgb.r;
  assign green_out_o    = res.rgb.g;
  assign blue_out_o     = res.rgb.b;
  assign last_o         = res.last;

endmodule
